[design/rlab_pkg.sv]
// ----------------------------------------------------------------------------
// rlab_pkg: shared types and constants for the RGBA layer alpha blend.
// Holds the channel widths, the divide-by-255 reciprocal, the register
// indexes and the request type of the pipelined channel divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rlab_pkg;

    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned OPA_W      = 9;
    localparam int unsigned DIV_STAGES = 4;
    localparam int unsigned DIV_BPS    = 2;
    localparam int unsigned LATENCY    = 5 + DIV_STAGES + 1;

    localparam logic [OPA_W-1:0] Q8_ONE    = 9'd256;
    localparam logic [CH_W-1:0]  FULL      = 8'd255;
    localparam logic [15:0]      RECIP_255 = 16'd32897;

    typedef enum logic {
        CFG_LAYER_OPACITY = 1'b0,
        CFG_DARKEN_ONLY   = 1'b1
    } t_cfg_idx;

    typedef logic [CH_W-1:0] t_ch;

    typedef struct packed {
        logic [16:0]     dividend;
        logic [CH_W-1:0] divisor;
    } t_div_req;

endpackage

`default_nettype wire

[design/rlab_div.sv]
// ----------------------------------------------------------------------------
// rlab_div: pipelined restoring divider for one color channel.
// Divides a 17-bit dividend by an 8-bit divisor, two quotient bits per
// stage, and saturates the quotient to 255 when it would not fit.
// ----------------------------------------------------------------------------
`default_nettype none

module rlab_div
    import rlab_pkg::*;
(
    input  wire logic            i_clk,
    input  wire t_div_req        i_req,
    output logic [CH_W-1:0]      o_quo
);

    typedef struct packed {
        logic            sat;
        logic [15:0]     rem;
        logic [CH_W-1:0] quo;
        logic [CH_W-1:0] div;
    } t_div_st;

    function automatic t_div_st div_step(t_div_st st, int unsigned bitpos);
        t_div_st     res;
        logic [15:0] trial;
        res   = st;
        trial = 16'({8'd0, st.div} << bitpos);
        if (st.rem >= trial) begin
            res.rem = st.rem - trial;
            res.quo = {st.quo[CH_W-2:0], 1'b1};
        end else begin
            res.quo = {st.quo[CH_W-2:0], 1'b0};
        end
        return res;
    endfunction

    t_div_st r_st [DIV_STAGES];
    t_div_st n_st [DIV_STAGES];
    t_div_st w_init;

    always_comb begin
        w_init.sat = i_req.dividend >= {1'b0, i_req.divisor, 8'd0};
        w_init.rem = i_req.dividend[15:0];
        w_init.quo = '0;
        w_init.div = i_req.divisor;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        always_comb begin
            t_div_st st;
            st = (k == 0) ? w_init : r_st[(k == 0) ? 0 : k - 1];
            for (int unsigned j = 0; j < DIV_BPS; j++) begin
                st = div_step(st, CH_W - 1 - k * DIV_BPS - j);
            end
            n_st[k] = st;
        end

        always_ff @(posedge i_clk) begin
            r_st[k] <= n_st[k];
        end
    end

    assign o_quo = r_st[DIV_STAGES-1].sat ? FULL : r_st[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

[design/rgba_layer_alpha_blend.sv]
// ----------------------------------------------------------------------------
// rgba_layer_alpha_blend: composites a source RGBA pixel over a destination
// pixel with the over operator, scaled by a Q8 layer opacity.
//
// A request is taken at a clock edge where start is high and busy is low.
// Busy is high only during reset and the cycle after it, so one request can
// enter on every cycle. Each request gives exactly one result, shown on the
// o_out_* ports for one cycle with o_strobe high. On its way to the strobe a
// request passes the input register and the multiply chain (five register
// stages, at most one multiplier deep each), the four-stage channel divider
// and the output register. The receiver cannot stall, so no result is ever
// held back. Configuration writes take effect at the edge where i_cfg_we is
// high and must only be made with no request in flight. Reset clears all
// requests in flight and restores opacity 1.0 and darken-only off.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_layer_alpha_blend
    import rlab_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [OPA_W-1:0] i_cfg_data,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [7:0]       i_src_blue,
    input  wire logic [7:0]       i_src_green,
    input  wire logic [7:0]       i_src_red,
    input  wire logic [7:0]       i_src_alpha,
    input  wire logic [7:0]       i_dst_blue,
    input  wire logic [7:0]       i_dst_green,
    input  wire logic [7:0]       i_dst_red,
    input  wire logic [7:0]       i_dst_alpha,
    output logic                  o_strobe,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_alpha
);

    typedef struct packed {
        logic               byp;
        logic [NUM_CH-1:0][CH_W-1:0] s;
        t_ch                sa;
        t_ch                na;
    } t_tail;

    logic [OPA_W-1:0] r_opacity;
    logic             r_darken;
    logic             r_rdy;
    logic [OPA_W-1:0] w_op;
    logic             w_accept;
    logic             w_dark;
    logic [9:0]       w_sum_s;
    logic [9:0]       w_sum_d;

    logic             r1_vld;
    t_ch              r1_s [NUM_CH];
    t_ch              r1_d [NUM_CH];
    t_ch              r1_sa;
    t_ch              r1_da;

    logic             r2_vld;
    t_ch              r2_s [NUM_CH];
    t_ch              r2_sa;
    t_ch              r2_da;
    logic [15:0]      r2_t;
    logic [15:0]      r2_dda [NUM_CH];

    logic             r3_vld;
    t_ch              r3_s [NUM_CH];
    t_ch              r3_sa;
    t_ch              r3_da;
    logic [15:0]      r3_t;
    logic [15:0]      r3_dda [NUM_CH];
    logic [15:0]      r3_ph;
    t_ch              r3_f [NUM_CH];

    logic             r4_vld;
    t_ch              r4_s [NUM_CH];
    t_ch              r4_sa;
    t_ch              r4_da;
    logic [15:0]      r4_dda [NUM_CH];
    t_ch              r4_nq;
    logic signed [26:0] r4_m [NUM_CH];

    logic             r5_vld;
    t_ch              r5_s [NUM_CH];
    t_ch              r5_sa;
    t_ch              r5_da;
    t_ch              r5_na;
    logic             r5_byp;
    logic [16:0]      r5_y [NUM_CH];

    logic             r_dvld [DIV_STAGES];
    t_tail            r_tail [DIV_STAGES];
    t_ch              w_quo [NUM_CH];

    logic             r_out_vld;
    t_ch              r_out_ch [NUM_CH];
    t_ch              r_out_a;

    t_ch              w_src [NUM_CH];
    t_ch              w_dst [NUM_CH];

    assign w_src[0] = i_src_blue;
    assign w_src[1] = i_src_green;
    assign w_src[2] = i_src_red;
    assign w_dst[0] = i_dst_blue;
    assign w_dst[1] = i_dst_green;
    assign w_dst[2] = i_dst_red;

    assign busy     = !r_rdy;
    assign w_accept = start && !busy;
    assign w_op     = (r_opacity > Q8_ONE) ? Q8_ONE : r_opacity;
    assign w_sum_s  = 10'(i_src_blue) + 10'(i_src_green) + 10'(i_src_red);
    assign w_sum_d  = 10'(i_dst_blue) + 10'(i_dst_green) + 10'(i_dst_red);
    assign w_dark   = r_darken && (w_sum_s > w_sum_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= Q8_ONE;
            r_darken  <= 1'b0;
            r_rdy     <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LAYER_OPACITY: r_opacity <= i_cfg_data;
                    CFG_DARKEN_ONLY:   r_darken  <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++) begin
                r_dvld[i] <= 1'b0;
            end
        end else begin
            r1_vld    <= w_accept;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r_dvld[0] <= r5_vld;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_dvld[i] <= r_dvld[i-1];
            end
            r_out_vld <= r_dvld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [23:0]        p;
        logic [31:0]        fm;
        logic [31:0]        nm;
        logic signed [9:0]  diff;
        logic [8:0]         na_sum;
        logic signed [26:0] num;

        r1_sa <= w_dark ? '0 : i_src_alpha;
        r1_da <= i_dst_alpha;
        for (int c = 0; c < NUM_CH; c++) begin
            r1_s[c] <= w_src[c];
            r1_d[c] <= w_dst[c];
        end

        r2_sa <= r1_sa;
        r2_da <= r1_da;
        r2_t  <= 16'(r1_sa * w_op);
        for (int c = 0; c < NUM_CH; c++) begin
            r2_s[c]   <= r1_s[c];
            r2_dda[c] <= 16'(r1_d[c] * r1_da);
        end

        p     = 24'(r2_t * (FULL - r2_da));
        r3_ph <= p[23:8];
        r3_sa <= r2_sa;
        r3_da <= r2_da;
        r3_t  <= r2_t;
        for (int c = 0; c < NUM_CH; c++) begin
            fm        = 32'(r2_dda[c] * RECIP_255);
            r3_f[c]   <= fm[30:23];
            r3_s[c]   <= r2_s[c];
            r3_dda[c] <= r2_dda[c];
        end

        nm    = 32'(r3_ph * RECIP_255);
        r4_nq <= nm[30:23];
        r4_sa <= r3_sa;
        r4_da <= r3_da;
        for (int c = 0; c < NUM_CH; c++) begin
            diff      = $signed({2'b0, r3_s[c]}) - $signed({2'b0, r3_f[c]});
            r4_m[c]   <= diff * $signed({11'd0, r3_t});
            r4_s[c]   <= r3_s[c];
            r4_dda[c] <= r3_dda[c];
        end

        na_sum = {1'b0, r4_da} + {1'b0, r4_nq};
        r5_na  <= na_sum[8] ? FULL : na_sum[7:0];
        r5_byp <= (r4_da == '0);
        r5_sa  <= r4_sa;
        r5_da  <= r4_da;
        for (int c = 0; c < NUM_CH; c++) begin
            num     = $signed({3'd0, r4_dda[c], 8'd0}) + r4_m[c];
            r5_y[c] <= num[26] ? '0 : num[24:8];
            r5_s[c] <= r4_s[c];
        end

        r_tail[0].byp <= r5_byp;
        r_tail[0].sa  <= r5_sa;
        r_tail[0].na  <= r5_na;
        for (int c = 0; c < NUM_CH; c++) begin
            r_tail[0].s[c] <= r5_s[c];
        end
        for (int i = 1; i < DIV_STAGES; i++) begin
            r_tail[i] <= r_tail[i-1];
        end

        r_out_a <= r_tail[DIV_STAGES-1].byp ? r_tail[DIV_STAGES-1].sa
                                            : r_tail[DIV_STAGES-1].na;
        for (int c = 0; c < NUM_CH; c++) begin
            r_out_ch[c] <= r_tail[DIV_STAGES-1].byp ? r_tail[DIV_STAGES-1].s[c]
                                                     : w_quo[c];
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_div
        t_div_req w_req;
        assign w_req.dividend = r5_y[c];
        assign w_req.divisor  = r5_na;

        rlab_div u_div (
            .i_clk (i_clk),
            .i_req (w_req),
            .o_quo (w_quo[c])
        );
    end

    assign o_strobe    = r_out_vld;
    assign o_out_blue  = r_out_ch[0];
    assign o_out_green = r_out_ch[1];
    assign o_out_red   = r_out_ch[2];
    assign o_out_alpha = r_out_a;

`ifndef SYNTHESIS
    a_latency_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("Result strobe without a matching request.");

    a_latency_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("Request did not produce a result.");

    a_alpha_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_vld && !r5_byp) |-> (r5_na >= r5_da && r5_na != '0))
        else $error("Combined alpha below destination alpha.");
`endif

endmodule

`default_nettype wire

[dv/rgba_layer_alpha_blend_checker.sv]
// ----------------------------------------------------------------------------
// rgba_layer_alpha_blend_checker: result checker for the RGBA layer blend.
// Follows the configuration writes and every accepted request, works out
// the composited pixel with its own integer model of the over operator and
// compares each strobed result, field by field, with the oldest pending one.
// ----------------------------------------------------------------------------
module rgba_layer_alpha_blend_checker
    import rlab_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [OPA_W-1:0] i_cfg_data,
    input  wire logic             i_start,
    input  wire logic             i_busy,
    input  wire logic [7:0]       i_src_blue,
    input  wire logic [7:0]       i_src_green,
    input  wire logic [7:0]       i_src_red,
    input  wire logic [7:0]       i_src_alpha,
    input  wire logic [7:0]       i_dst_blue,
    input  wire logic [7:0]       i_dst_green,
    input  wire logic [7:0]       i_dst_red,
    input  wire logic [7:0]       i_dst_alpha,
    input  wire logic             i_strobe,
    input  wire logic [7:0]       i_out_blue,
    input  wire logic [7:0]       i_out_green,
    input  wire logic [7:0]       i_out_red,
    input  wire logic [7:0]       i_out_alpha,
    output int                    o_pending,
    output int                    o_fail_count
);

    typedef struct packed {
        t_ch blue;
        t_ch green;
        t_ch red;
        t_ch alpha;
    } t_pixel;

    logic [OPA_W-1:0] layer_opacity;
    logic             darken_only;
    t_pixel           blended_pixels[$];
    int               fail_count = 0;

    assign o_pending    = blended_pixels.size();
    assign o_fail_count = fail_count;

    function automatic t_ch blend_one_channel(t_ch s, t_ch d, t_ch da,
                                              int unsigned t, int unsigned na);
        longint dda;
        longint num;
        longint q;
        dda = longint'(d) * longint'(da);
        num = dda * 256 + (longint'(s) - dda / 255) * longint'(t);
        q   = num / (longint'(na) * 256);
        if (q < 0) begin
            q = 0;
        end
        if (q > 255) begin
            q = 255;
        end
        return t_ch'(q);
    endfunction

    function automatic t_pixel composite_over(t_pixel s, t_pixel d,
                                              logic [OPA_W-1:0] opa, logic dk);
        t_pixel      res;
        t_ch         sa;
        int unsigned op;
        int unsigned t;
        int unsigned na;
        sa = s.alpha;
        if (dk && (int'(s.blue) + int'(s.green) + int'(s.red)) >
                  (int'(d.blue) + int'(d.green) + int'(d.red))) begin
            sa = '0;
        end
        if (d.alpha == '0) begin
            res = '{blue: s.blue, green: s.green, red: s.red, alpha: sa};
            return res;
        end
        op = (opa > Q8_ONE) ? int'(Q8_ONE) : int'(opa);
        t  = sa * op;
        na = d.alpha + (t * (FULL - d.alpha)) / 65280;
        if (na > FULL) begin
            na = FULL;
        end
        res.blue  = blend_one_channel(s.blue, d.blue, d.alpha, t, na);
        res.green = blend_one_channel(s.green, d.green, d.alpha, t, na);
        res.red   = blend_one_channel(s.red, d.red, d.alpha, t, na);
        res.alpha = t_ch'(na);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            layer_opacity <= Q8_ONE;
            darken_only   <= 1'b0;
            blended_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_LAYER_OPACITY) begin
                    layer_opacity <= i_cfg_data;
                end else begin
                    darken_only <= i_cfg_data[0];
                end
            end
            if (i_strobe) begin
                if (blended_pixels.size() == 0) begin
                    report_mismatch("result with no request pending, alpha",
                                    i_out_alpha, 0);
                end else begin
                    want = blended_pixels.pop_front();
                    if (i_out_blue !== want.blue) begin
                        report_mismatch("out_blue", i_out_blue, want.blue);
                    end
                    if (i_out_green !== want.green) begin
                        report_mismatch("out_green", i_out_green, want.green);
                    end
                    if (i_out_red !== want.red) begin
                        report_mismatch("out_red", i_out_red, want.red);
                    end
                    if (i_out_alpha !== want.alpha) begin
                        report_mismatch("out_alpha", i_out_alpha, want.alpha);
                    end
                end
            end
            if (i_start && !i_busy) begin
                blended_pixels.push_back(composite_over(
                    '{i_src_blue, i_src_green, i_src_red, i_src_alpha},
                    '{i_dst_blue, i_dst_green, i_dst_red, i_dst_alpha},
                    layer_opacity, darken_only));
            end
        end
    end

endmodule

[dv/rgba_layer_alpha_blend_test.sv]
// ----------------------------------------------------------------------------
// rgba_layer_alpha_blend_test: top level of the RGBA layer blend testbench.
// Resets the block once, then runs a series of configuration phases: the
// reset setting, the opacity and darken-only extremes and random settings.
// Each phase sends pixel pairs with random gaps or back to back, a short
// directed set of corner pixels in the first two phases. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module rgba_layer_alpha_blend_test;
    import rlab_pkg::*;

    localparam int NUM_PHASES      = 10;
    localparam int PIXELS_PER_PHASE = 145;
    localparam int STALL_LIMIT     = 1000;

    typedef struct packed {
        t_ch blue;
        t_ch green;
        t_ch red;
        t_ch alpha;
    } t_rgba;

    // Source pixel in the upper half, destination pixel in the lower half.
    localparam logic [63:0] CORNER_PAIRS [12] = '{
        64'h00000000_00000000,
        64'hFFFFFFFF_FFFFFFFF,
        64'h0A141EC8_05050500,
        64'hC8C8C8FF_0A0A0A00,
        64'h00000000_6496C880,
        64'h000000FF_FFFFFFFF,
        64'hFFFFFFFF_00000001,
        64'h000000FF_FFFFFF01,
        64'hFF00FF80_00FF0040,
        64'h01020301_FEFDFCFE,
        64'h80402010_204080F0,
        64'hFFFFFFFF_FFFFFF00
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_idx = CFG_LAYER_OPACITY;
    logic [OPA_W-1:0] cfg_data = '0;
    logic             start = 1'b0;
    logic             busy;
    t_rgba            src_px = '0;
    t_rgba            dst_px = '0;
    logic             o_strobe;
    logic [7:0]       o_out_blue;
    logic [7:0]       o_out_green;
    logic [7:0]       o_out_red;
    logic [7:0]       o_out_alpha;
    int               pending;
    int               fail_count;
    int               stall_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    rgba_layer_alpha_blend i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .start       (start),
        .busy        (busy),
        .i_src_blue  (src_px.blue),
        .i_src_green (src_px.green),
        .i_src_red   (src_px.red),
        .i_src_alpha (src_px.alpha),
        .i_dst_blue  (dst_px.blue),
        .i_dst_green (dst_px.green),
        .i_dst_red   (dst_px.red),
        .i_dst_alpha (dst_px.alpha),
        .o_strobe    (o_strobe),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_out_alpha (o_out_alpha)
    );

    rgba_layer_alpha_blend_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_start      (start),
        .i_busy       (busy),
        .i_src_blue   (src_px.blue),
        .i_src_green  (src_px.green),
        .i_src_red    (src_px.red),
        .i_src_alpha  (src_px.alpha),
        .i_dst_blue   (dst_px.blue),
        .i_dst_green  (dst_px.green),
        .i_dst_red    (dst_px.red),
        .i_dst_alpha  (dst_px.alpha),
        .i_strobe     (o_strobe),
        .i_out_blue   (o_out_blue),
        .i_out_green  (o_out_green),
        .i_out_red    (o_out_red),
        .i_out_alpha  (o_out_alpha),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL rgba_layer_alpha_blend");
            $finish;
        end
    end

    function automatic t_ch random_alpha();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return t_ch'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_rgba random_pixel();
        t_rgba px;
        px.blue  = t_ch'($urandom_range(0, 255));
        px.green = t_ch'($urandom_range(0, 255));
        px.red   = t_ch'($urandom_range(0, 255));
        px.alpha = random_alpha();
        return px;
    endfunction

    task automatic send_pixel_pair(t_rgba s, t_rgba d, int gap);
        bit taken;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        src_px <= s;
        dst_px <= d;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [OPA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [OPA_W-1:0] opacity;
        logic             darken;
        bit               quiet;
        int               gap;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1: begin opacity = 9'd511; darken = 1'b1; end
                2: begin opacity = 9'd0;   darken = 1'b0; end
                3: begin opacity = 9'd257; darken = 1'b1; end
                4: begin opacity = 9'd1;   darken = 1'b0; end
                5: begin opacity = 9'd255; darken = 1'b1; end
                default: begin
                    opacity = OPA_W'($urandom_range(0, 511));
                    darken  = 1'($urandom_range(0, 1));
                end
            endcase
            if (p > 0) begin
                drain_requests();
                write_register(CFG_LAYER_OPACITY, opacity);
                write_register(CFG_DARKEN_ONLY, OPA_W'(darken));
            end
            if (p < 2) begin
                foreach (CORNER_PAIRS[k]) begin
                    send_pixel_pair(t_rgba'(CORNER_PAIRS[k][63:32]),
                                    t_rgba'(CORNER_PAIRS[k][31:0]),
                                    $urandom_range(0, 1) ? 0 : $urandom_range(1, 18));
                end
            end
            quiet = (p % 3 == 2);
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                if (quiet || $urandom_range(0, 2) == 0) begin
                    gap = 0;
                end else begin
                    gap = $urandom_range(0, 18);
                end
                send_pixel_pair(random_pixel(), random_pixel(), gap);
            end
        end
        drain_requests();
        if (fail_count == 0) begin
            $display("PASS rgba_layer_alpha_blend");
        end else begin
            $display("FAIL rgba_layer_alpha_blend");
        end
        $finish;
    end

endmodule

[sim.f]
design/rlab_pkg.sv
design/rlab_div.sv
design/rgba_layer_alpha_blend.sv
dv/rgba_layer_alpha_blend_checker.sv
dv/rgba_layer_alpha_blend_test.sv
